FILE: hw/rtl/mf3_pkg.sv
// Shared types, sizes and compare helpers for the 3x3 median filter.
// Used by mf3_line_window, mf3_median9 and median_filter_3x3.
`timescale 1ns / 1ps
`default_nettype none

package mf3_pkg;

  localparam int MAX_WIDTH    = 128;
  localparam int MAX_HEIGHT   = 1024;
  localparam int RESET_WIDTH  = 126;
  localparam int RESET_HEIGHT = 96;

  localparam int PIX_W        = 8;
  localparam int WIDTH_REG_W  = 8;
  localparam int HEIGHT_REG_W = 11;
  localparam int CFG_DATA_W   = (WIDTH_REG_W > HEIGHT_REG_W) ? WIDTH_REG_W : HEIGHT_REG_W;
  localparam int CFG_IDX_W    = 1;

  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int ROW_W  = $clog2(MAX_HEIGHT);
  localparam int WDIM_W = COL_W + 1;
  localparam int HDIM_W = ROW_W + 1;

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = CFG_IDX_W'(1);

  typedef logic [PIX_W-1:0] pix_t;
  typedef logic [8:0][PIX_W-1:0] win_t;

  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] column;
    logic             last;
  } meta_t;

  // what travels with a pixel from the counters to the line stores
  typedef struct packed {
    logic             emit;
    logic [COL_W-1:0] addr;
    meta_t            meta;
  } tag_t;

  typedef struct packed {
    pix_t hi;
    pix_t mid;
    pix_t lo;
  } sort3_t;

  function automatic pix_t min2(pix_t a, pix_t b);
    return (a < b) ? a : b;
  endfunction

  function automatic pix_t max2(pix_t a, pix_t b);
    return (a < b) ? b : a;
  endfunction

  function automatic pix_t med3(pix_t a, pix_t b, pix_t c);
    return max2(min2(a, b), min2(max2(a, b), c));
  endfunction

  function automatic sort3_t sort3(pix_t a, pix_t b, pix_t c);
    sort3_t s;
    s.lo  = min2(min2(a, b), c);
    s.hi  = max2(max2(a, b), c);
    s.mid = med3(a, b, c);
    return s;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/median_filter_3x3.sv
// 3x3 median filter: top level with configuration registers and position counters.
// Depends on mf3_pkg, mf3_line_window and mf3_median9.
//
// Usage:
//   Pixels of an 8-bit grey frame enter in raster order on in_pixel, one per
//   transfer (in_valid high, in_stall low). For every interior pixel a result
//   leaves on out_median/out_row/out_column with out_last_of_frame set on the
//   final interior pixel; border pixels give nothing.
//   image_width (index 0) and image_height (index 1) are written through
//   cfg_wr_en/cfg_index/cfg_wdata; the user must write them only between frames,
//   which the block does not enforce; values are saturated into 3..128 and 3..1024.
//   Throughput: one pixel per cycle while in_stall is low. The transfer edge
//   loads the line-store read stage, then row sort, candidates and final pick
//   are registered in turn (four register stages).
//   A stalled result holds in the output register; the pipeline keeps taking
//   pixels until its stages are full, then raises in_stall.
//   Reset clears the counters, the window and the registers to 126 x 96.
//   The line stores are not cleared; every entry that feeds a result has been
//   written by the two rows above it.
`timescale 1ns / 1ps
`default_nettype none

module median_filter_3x3
  import mf3_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    in_valid,
  output logic                         in_stall,
  input  wire logic [PIX_W-1:0]        in_pixel,
  output logic                         out_valid,
  input  wire logic                    out_stall,
  output logic [PIX_W-1:0]             out_median,
  output logic [ROW_W-1:0]             out_row,
  output logic [COL_W-1:0]             out_column,
  output logic                         out_last_of_frame,
  input  wire logic                    cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [CFG_DATA_W-1:0]   cfg_wdata
);

  logic [WIDTH_REG_W-1:0]  width_r;
  logic [HEIGHT_REG_W-1:0] height_r;
  logic [WDIM_W-1:0]       w_eff;
  logic [HDIM_W-1:0]       h_eff;
  logic [COL_W-1:0]        col_r;
  logic [ROW_W-1:0]        row_r;
  logic [WDIM_W-1:0]       col_inc;
  logic [HDIM_W-1:0]       row_inc;
  logic                    acc;
  logic                    win_ready;
  tag_t                    tag;
  logic                    mid_valid;
  logic                    mid_ready;
  win_t                    mid_win;
  meta_t                   mid_meta;
  meta_t                   res_meta;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_REG_W'(RESET_WIDTH);
      height_r <= HEIGHT_REG_W'(RESET_HEIGHT);
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_IMAGE_WIDTH:  width_r  <= cfg_wdata[WIDTH_REG_W-1:0];
        REG_IMAGE_HEIGHT: height_r <= cfg_wdata[HEIGHT_REG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (32'(width_r) < 32'd3)              w_eff = WDIM_W'(3);
    else if (32'(width_r) > 32'(MAX_WIDTH)) w_eff = WDIM_W'(MAX_WIDTH);
    else                                    w_eff = WDIM_W'(width_r);
    if (32'(height_r) < 32'd3)               h_eff = HDIM_W'(3);
    else if (32'(height_r) > 32'(MAX_HEIGHT)) h_eff = HDIM_W'(MAX_HEIGHT);
    else                                      h_eff = HDIM_W'(height_r);
  end

  assign acc      = in_valid && win_ready;
  assign in_stall = !win_ready;
  assign col_inc  = {1'b0, col_r} + WDIM_W'(1);
  assign row_inc  = {1'b0, row_r} + HDIM_W'(1);

  always_comb begin
    tag.addr        = col_r;
    tag.emit        = ({1'b0, col_r} < w_eff) && ({1'b0, row_r} < h_eff) &&
                      (col_r >= COL_W'(2)) && (row_r >= ROW_W'(2));
    tag.meta.row    = row_r - ROW_W'(1);
    tag.meta.column = col_r - COL_W'(1);
    tag.meta.last   = (col_inc == w_eff) && (row_inc == h_eff);
  end

  // position of the next pixel; wraps early if the frame shrank between frames
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (acc) begin
      if (col_inc >= w_eff) begin
        col_r <= '0;
        row_r <= (row_inc >= h_eff) ? '0 : row_inc[ROW_W-1:0];
      end else begin
        col_r <= col_inc[COL_W-1:0];
      end
    end
  end

  mf3_line_window u_window (
    .clk      (clk),
    .rst_n    (rst_n),
    .acc      (acc),
    .pixel    (in_pixel),
    .tag      (tag),
    .ready    (win_ready),
    .dn_valid (mid_valid),
    .dn_ready (mid_ready),
    .dn_win   (mid_win),
    .dn_meta  (mid_meta)
  );

  mf3_median9 u_median (
    .clk        (clk),
    .rst_n      (rst_n),
    .up_valid   (mid_valid),
    .up_ready   (mid_ready),
    .up_win     (mid_win),
    .up_meta    (mid_meta),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_median (out_median),
    .out_meta   (res_meta)
  );

  assign out_row           = res_meta.row;
  assign out_column        = res_meta.column;
  assign out_last_of_frame = res_meta.last;

  // a centre pixel is never on the top row or left column
  a_interior: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_row != '0) && (out_column != '0))
    else $error("result for a border pixel");

  // width is at least three, so every transfer moves the column
  a_col_moves: assert property (@(posedge clk) disable iff (!rst_n)
    acc |=> (col_r != $past(col_r)))
    else $error("column counter did not move on a transfer");

  // last interior pixel sits one left of the final column
  a_last_col: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last_of_frame) |-> (out_column == COL_W'(w_eff - WDIM_W'(2))))
    else $error("end-of-frame flag on the wrong column");

endmodule

`default_nettype wire

FILE: hw/rtl/mf3_line_window.sv
// Two line stores (synchronous RAMs with registered read) and the 3x3 window.
// Depends on mf3_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mf3_line_window
  import mf3_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  acc,        // pixel transfer into the block
  input  wire pix_t  pixel,
  input  wire tag_t  tag,
  output logic       ready,      // may take a pixel this cycle
  output logic       dn_valid,
  input  wire logic  dn_ready,
  output win_t       dn_win,
  output meta_t      dn_meta
);

  pix_t upper_mem  [MAX_WIDTH];
  pix_t middle_mem [MAX_WIDTH];

  pix_t up_rd_r;
  pix_t mid_rd_r;
  logic s1_v_r;
  pix_t s1_px_r;
  tag_t s1_tag_r;
  win_t win_r;
  win_t win_nxt;
  logic adv;

  // Consecutive pixels always address different columns (width is at least
  // three), so the write-back of one never meets the read of the next.
  always_ff @(posedge clk) begin
    if (acc) begin
      up_rd_r  <= upper_mem[tag.addr];
      mid_rd_r <= middle_mem[tag.addr];
    end
    if (adv) begin
      upper_mem[s1_tag_r.addr]  <= mid_rd_r;
      middle_mem[s1_tag_r.addr] <= s1_px_r;
    end
  end

  // border pixels leave without waiting for the median pipeline
  assign adv   = s1_v_r && (dn_ready || !s1_tag_r.emit);
  assign ready = !s1_v_r || adv;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      win_nxt[3*k]   = win_r[3*k+1];
      win_nxt[3*k+1] = win_r[3*k+2];
    end
    win_nxt[2] = up_rd_r;
    win_nxt[5] = mid_rd_r;
    win_nxt[8] = s1_px_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      win_r  <= '0;
    end else begin
      if (ready) begin
        s1_v_r <= acc;
      end
      if (adv) begin
        win_r <= win_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_px_r  <= pixel;
      s1_tag_r <= tag;
    end
  end

  assign dn_valid = s1_v_r && s1_tag_r.emit;
  assign dn_win   = win_nxt;
  assign dn_meta  = s1_tag_r.meta;

endmodule

`default_nettype wire

FILE: hw/rtl/mf3_median9.sv
// Three-stage median of nine: sort rows, reduce to three candidates, pick.
// Depends on mf3_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mf3_median9
  import mf3_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  up_valid,
  output logic       up_ready,
  input  wire win_t  up_win,
  input  wire meta_t up_meta,
  output logic       out_valid,
  input  wire logic  out_stall,
  output pix_t       out_median,
  output meta_t      out_meta
);

  logic   a_v_r, b_v_r, o_v_r;
  logic   a_ready, b_ready, o_ready;
  sort3_t a_row_r [3];
  meta_t  a_meta_r, b_meta_r, o_meta_r;
  pix_t   b_lo_r, b_mid_r, b_hi_r;
  pix_t   o_med_r;

  assign o_ready  = !o_v_r || !out_stall;
  assign b_ready  = !b_v_r || o_ready;
  assign a_ready  = !a_v_r || b_ready;
  assign up_ready = a_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
      b_v_r <= 1'b0;
      o_v_r <= 1'b0;
    end else begin
      if (a_ready) a_v_r <= up_valid;
      if (b_ready) b_v_r <= a_v_r;
      if (o_ready) o_v_r <= b_v_r;
    end
  end

  // median = med3(max of row minima, median of row medians, min of row maxima)
  always_ff @(posedge clk) begin
    if (a_ready && up_valid) begin
      for (int k = 0; k < 3; k++) begin
        a_row_r[k] <= sort3(up_win[3*k], up_win[3*k+1], up_win[3*k+2]);
      end
      a_meta_r <= up_meta;
    end
    if (b_ready && a_v_r) begin
      b_lo_r   <= max2(max2(a_row_r[0].lo, a_row_r[1].lo), a_row_r[2].lo);
      b_mid_r  <= med3(a_row_r[0].mid, a_row_r[1].mid, a_row_r[2].mid);
      b_hi_r   <= min2(min2(a_row_r[0].hi, a_row_r[1].hi), a_row_r[2].hi);
      b_meta_r <= a_meta_r;
    end
    if (o_ready && b_v_r) begin
      o_med_r  <= med3(b_lo_r, b_mid_r, b_hi_r);
      o_meta_r <= b_meta_r;
    end
  end

  assign out_valid  = o_v_r;
  assign out_median = o_med_r;
  assign out_meta   = o_meta_r;

endmodule

`default_nettype wire

FILE: test/median_filter_3x3_tb.sv
// Self-checking bench for median_filter_3x3: streams grey frames of many sizes,
// predicts every interior median with its position and checks each result transfer.
// Depends on mf3_pkg and the median_filter_3x3 RTL; no files or arguments.
`timescale 1ns / 1ps

module median_filter_3x3_tb;
  import mf3_pkg::*;

  localparam int CLK_HALF       = 10;
  localparam int RESET_CYCLES   = 12;
  localparam int IDLE_PCT       = 19;
  localparam int RANDOM_PIXELS  = 400;
  localparam int TALL_ROWS      = 96;
  localparam int SETTLE_CYCLES  = 8;     // four-stage pipeline plus margin
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int HOLD_START     = 940;   // lands inside the tall narrow frame
  localparam int HOLD_CYCLES    = 300;
  localparam int QUIET_FROM     = 980;
  localparam int QUIET_TO       = 1180;

  // nine pixels in raster order for the hand-made 3x3 frame
  localparam win_t MIXED_SET = {8'd200, 8'd10, 8'd255, 8'd0, 8'd128,
                                8'd77, 8'd128, 8'd3, 8'd90};

  typedef struct packed {
    pix_t             median;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] column;
    logic             last;
  } filtered_px_t;

  typedef enum int { CONTENT_NOISE, CONTENT_BLACK_WHITE, CONTENT_FLAT } content_t;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  pix_t                  in_pixel  = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  pix_t                  out_median;
  logic [ROW_W-1:0]      out_row;
  logic [COL_W-1:0]      out_column;
  logic                  out_last_of_frame;
  logic                  cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_IMAGE_WIDTH;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  // filter state mirrored by the bench
  pix_t                    upper_line [MAX_WIDTH];
  pix_t                    middle_line [MAX_WIDTH];
  win_t                    nbhd;
  int unsigned             col_pos;
  int unsigned             row_pos;
  logic [WIDTH_REG_W-1:0]  width_reg;
  logic [HEIGHT_REG_W-1:0] height_reg;

  filtered_px_t medians_due[$];
  pix_t         pixels_to_send[$];
  filtered_px_t due_px;
  int           accepted_pixels = 0;
  int           mismatch_count  = 0;
  int           hold_left       = 0;
  bit           hold_done       = 1'b0;
  int           stuck_cycles    = 0;

  median_filter_3x3 u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_pixel          (in_pixel),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_median        (out_median),
    .out_row           (out_row),
    .out_column        (out_column),
    .out_last_of_frame (out_last_of_frame),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata)
  );

  always #CLK_HALF clk = ~clk;

  function automatic int unsigned eff_width();
    if (width_reg < 3) return 3;
    if (width_reg > MAX_WIDTH) return MAX_WIDTH;
    return 32'(width_reg);
  endfunction

  function automatic int unsigned eff_height();
    if (height_reg < 3) return 3;
    if (height_reg > MAX_HEIGHT) return MAX_HEIGHT;
    return 32'(height_reg);
  endfunction

  function automatic bit quiet_now();
    return accepted_pixels >= QUIET_FROM && accepted_pixels < QUIET_TO;
  endfunction

  // rank selection: the median has at most four smaller and at least five not larger
  function automatic pix_t median_of_nine(win_t w);
    int below;
    int not_above;
    for (int i = 0; i < 9; i++) begin
      below = 0;
      not_above = 0;
      for (int j = 0; j < 9; j++) begin
        if (w[j] < w[i]) below++;
        if (w[j] <= w[i]) not_above++;
      end
      if (below <= 4 && not_above >= 5) return w[i];
    end
    return '0;
  endfunction

  task automatic filter_step(pix_t px);
    int unsigned w;
    int unsigned h;
    int unsigned c;
    int unsigned r;
    logic [COL_W-1:0] idx;
    pix_t up;
    pix_t mid;
    filtered_px_t res;
    w = eff_width();
    h = eff_height();
    c = col_pos;
    r = row_pos;
    idx = COL_W'(c);
    up = upper_line[idx];
    mid = middle_line[idx];
    for (int k = 0; k < 3; k++) begin
      nbhd[3*k]   = nbhd[3*k+1];
      nbhd[3*k+1] = nbhd[3*k+2];
    end
    nbhd[2] = up;
    nbhd[5] = mid;
    nbhd[8] = px;
    upper_line[idx] = mid;
    middle_line[idx] = px;
    if (c < w && r < h && c >= 2 && r >= 2) begin
      res.median = median_of_nine(nbhd);
      res.row    = ROW_W'(r - 1);
      res.column = COL_W'(c - 1);
      res.last   = (c == w - 1 && r == h - 1);
      medians_due.push_back(res);
    end
    // positions beyond a shrunk frame wrap at once
    if (c + 1 >= w) begin
      col_pos = 0;
      row_pos = (r + 1 >= h) ? 0 : r + 1;
    end else begin
      col_pos = c + 1;
    end
  endtask

  // pixel driver: a new pixel only once the previous one has transferred
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        filter_step(in_pixel);
        accepted_pixels <= accepted_pixels + 1;
      end
      if (!in_valid || !in_stall) begin
        if (pixels_to_send.size() > 0 && (quiet_now() || $urandom_range(99) >= IDLE_PCT)) begin
          in_pixel <= pixels_to_send.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result side back-pressure, with one long hold so the pipeline fills
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (!hold_done && accepted_pixels >= HOLD_START) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !quiet_now() && ($urandom_range(99) < IDLE_PCT);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (medians_due.size() == 0) begin
        $error("unexpected result: median %0d row %0d column %0d last %0d",
               out_median, out_row, out_column, out_last_of_frame);
        mismatch_count++;
      end else begin
        due_px = medians_due.pop_front();
        if (out_median !== due_px.median) begin
          $error("median: expected %0d, got %0d", due_px.median, out_median);
          mismatch_count++;
        end
        if (out_row !== due_px.row) begin
          $error("row: expected %0d, got %0d", due_px.row, out_row);
          mismatch_count++;
        end
        if (out_column !== due_px.column) begin
          $error("column: expected %0d, got %0d", due_px.column, out_column);
          mismatch_count++;
        end
        if (out_last_of_frame !== due_px.last) begin
          $error("last_of_frame: expected %0d, got %0d", due_px.last, out_last_of_frame);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
      if (stuck_cycles >= WATCHDOG_LIMIT) begin
        $display("median_filter_3x3: mismatch");
        $finish;
      end
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    if (idx == REG_IMAGE_WIDTH) width_reg = value[WIDTH_REG_W-1:0];
    else height_reg = value[HEIGHT_REG_W-1:0];
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic queue_pixels(int unsigned count, content_t mode);
    pix_t level;
    level = pix_t'($urandom);
    @(negedge clk);
    repeat (count) begin
      case (mode)
        CONTENT_BLACK_WHITE: pixels_to_send.push_back($urandom_range(1) ? 8'hFF : 8'h00);
        CONTENT_FLAT: pixels_to_send.push_back(level + pix_t'($urandom_range(2)));
        default: pixels_to_send.push_back(pix_t'($urandom));
      endcase
    end
  endtask

  // border pixels leave nothing to wait for, hence the settle cycles
  task automatic wait_idle();
    do @(negedge clk);
    while (pixels_to_send.size() != 0 || in_valid || medians_due.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  initial begin
    logic [CFG_DATA_W-1:0] value;
    int unsigned           roll;
    int unsigned           w;
    int unsigned           h;
    int unsigned           len;
    int unsigned           random_sent;
    content_t              mode;

    for (int i = 0; i < MAX_WIDTH; i++) begin
      upper_line[i] = '0;
      middle_line[i] = '0;
    end
    nbhd = '0;
    col_pos = 0;
    row_pos = 0;
    width_reg = WIDTH_REG_W'(RESET_WIDTH);
    height_reg = HEIGHT_REG_W'(RESET_HEIGHT);
    random_sent = 0;

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // three rows at the reset geometry
    queue_pixels(3 * RESET_WIDTH, CONTENT_NOISE);
    wait_idle();

    // widen mid-frame: the first row sits outside the new 128x3 frame and
    // fills the two store entries the narrower rows never reached
    write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'(MAX_WIDTH));
    write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'(3));
    queue_pixels(4 * MAX_WIDTH, CONTENT_NOISE);
    wait_idle();

    // both sizes saturate up to 3: all black, all white, then a mixed set
    write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'(2));
    write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'(0));
    @(negedge clk);
    repeat (9) pixels_to_send.push_back(8'h00);
    repeat (9) pixels_to_send.push_back(8'hFF);
    for (int i = 8; i >= 0; i--) pixels_to_send.push_back(MIXED_SET[i]);
    wait_idle();

    // narrow frame with height saturated down to the maximum
    write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'(3));
    write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'(2047));
    queue_pixels(3 * TALL_ROWS, CONTENT_NOISE);
    wait_idle();

    while (random_sent < RANDOM_PIXELS) begin
      if ($urandom_range(99) < 60) begin
        if ($urandom_range(1)) begin
          roll = $urandom_range(99);
          if (roll < 65) value = CFG_DATA_W'($urandom_range(16, 3));
          else if (roll < 80) value = CFG_DATA_W'($urandom_range(MAX_WIDTH, 100));
          else if (roll < 90) value = CFG_DATA_W'($urandom_range(2, 0));
          else value = CFG_DATA_W'($urandom_range(255, MAX_WIDTH + 1));
          write_reg(REG_IMAGE_WIDTH, value);
        end
        if ($urandom_range(1)) begin
          roll = $urandom_range(99);
          if (roll < 70) value = CFG_DATA_W'($urandom_range(10, 3));
          else if (roll < 85) value = CFG_DATA_W'($urandom_range(2, 0));
          else value = CFG_DATA_W'($urandom_range(2047, MAX_HEIGHT));
          write_reg(REG_IMAGE_HEIGHT, value);
        end
      end
      w = eff_width();
      h = eff_height();
      // mostly finish the current frame, now and then stop part way through
      if (w * h > 300 || $urandom_range(99) < 30) begin
        len = $urandom_range(3 * w, 1);
      end else begin
        len = (col_pos < w && row_pos < h) ? (h - row_pos) * w - col_pos : w;
        len += $urandom_range(1) * w * h;
      end
      if (random_sent + len > RANDOM_PIXELS) len = RANDOM_PIXELS - random_sent;
      roll = $urandom_range(99);
      if (roll < 75) mode = CONTENT_NOISE;
      else if (roll < 88) mode = CONTENT_BLACK_WHITE;
      else mode = CONTENT_FLAT;
      queue_pixels(len, mode);
      random_sent += len;
      wait_idle();
    end

    repeat (20) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("median_filter_3x3: match");
    end else begin
      $display("median_filter_3x3: mismatch");
    end
    $finish;
  end

endmodule
